/* hw/rtl/lscc_pkg.sv */
// Package for the line sensor calibrate/centroid block.
// Holds the channel count, widths, command codes, register indexes and the divider control type.
// No dependencies.
package lscc_pkg;
  localparam int NumCh = 4;
  localparam int ScaleW = 10;
  localparam int ThrW = 12;
  localparam int NormW = 12;
  localparam int ErrW = 16;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 12;
  localparam logic CmdCalibrate = 1'b0;
  localparam logic CmdMeasure = 1'b1;
  localparam logic [CfgIdxW-1:0] RegNormScale = 1'b0;
  localparam logic [CfgIdxW-1:0] RegDetectThr = 1'b1;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;
endpackage

/* hw/rtl/lscc_divider.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses lscc_pkg for the control struct.
module lscc_divider #(
  parameter int NumW = 32,
  parameter int DenW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [DenW-1:0]     den_i,
  output lscc_pkg::div_ctrl_t ctrl_o,
  output logic [NumW-1:0]     quot_o
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[DenW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign ctrl_o = '{start: start_i, busy: busy_q, done: done_q};
  assign quot_o = quot_q;
endmodule

/* hw/rtl/line_sensor_calibrate_centroid_top.sv */
// Top level of the line sensor calibration and centroid block.
// Depends on lscc_pkg and lscc_divider.
//
// Channel   Handshake               Payload
// input     in_valid_i / in_stall_o command_i, sample_0_i..sample_3_i
// output    out_valid_o / out_stall_i line_error_o, line_lost_o, norm_0_o..norm_3_o
// config    cfg_we_i                cfg_idx_i, cfg_data_i
//
// A calibrate word goes from the accepting cycle straight to the result state.
// A measure word runs on one shared bit-serial divider of DivW bits, 30 at the default
// sample width: it divides once per windowed channel, skips flat channels, then divides
// once more for the centroid, or skips that division when the line is lost.
// Reset clears the calibration windows at once; no clearing pass.
// A finished word waits until the result register is empty or being taken, and the
// next word can be taken in the cycle after that.
module line_sensor_calibrate_centroid_top #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 command_i,
  input  logic [SAMPLE_BITS-1:0]               sample_0_i,
  input  logic [SAMPLE_BITS-1:0]               sample_1_i,
  input  logic [SAMPLE_BITS-1:0]               sample_2_i,
  input  logic [SAMPLE_BITS-1:0]               sample_3_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lscc_pkg::ErrW-1:0]     line_error_o,
  output logic                                 line_lost_o,
  output logic [lscc_pkg::NormW-1:0]           norm_0_o,
  output logic [lscc_pkg::NormW-1:0]           norm_1_o,
  output logic [lscc_pkg::NormW-1:0]           norm_2_o,
  output logic [lscc_pkg::NormW-1:0]           norm_3_o,
  input  logic                                 cfg_we_i,
  input  logic [lscc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [lscc_pkg::CfgDataW-1:0]        cfg_data_i
);
  localparam int SW = SAMPLE_BITS;
  localparam int NC = lscc_pkg::NumCh;
  localparam int NvW = (SW > lscc_pkg::NormW) ? SW : lscc_pkg::NormW;
  localparam int DivW = NvW + 18;
  localparam int ChW = $clog2(NC);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StNorm = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StCent = 3'd3;
  localparam logic [2:0] StCWait = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  logic [2:0] st_q, st_d;
  logic [ChW-1:0] ch_q, ch_d;
  logic [SW-1:0] smp_q [NC];
  logic [SW-1:0] mn_q [NC];
  logic [SW-1:0] mx_q [NC];
  logic [NvW-1:0] nv_q [NC];
  logic first_q;
  logic cmd_q;
  logic [lscc_pkg::ScaleW-1:0] scale_q;
  logic [lscc_pkg::ThrW-1:0] thr_q;
  logic [DivW-1:0] pos_q, wsum_q;
  logic neg_q;
  logic ovalid_q;
  logic signed [lscc_pkg::ErrW-1:0] err_q;
  logic lost_q;
  logic [lscc_pkg::NormW-1:0] onorm_q [NC];

  logic div_start;
  logic [DivW-1:0] div_num, div_den, div_quot;
  lscc_pkg::div_ctrl_t div_ctrl;

  logic in_acc, out_free;
  assign out_free = !ovalid_q || !out_stall_i;
  assign in_stall_o = (st_q != StIdle);
  assign in_acc = in_valid_i && !in_stall_o;

  lscc_divider #(.NumW(DivW), .DenW(DivW)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(div_num), .den_i(div_den), .ctrl_o(div_ctrl), .quot_o(div_quot)
  );

  logic [SW-1:0] lo, hi, v;
  logic flat;
  logic [NvW-1:0] nvc;
  logic [DivW-1:0] offs16, num_pos, num_neg;
  always_comb begin
    lo = mn_q[ch_q];
    hi = mx_q[ch_q];
    flat = (hi <= lo);
    v = smp_q[ch_q];
    if (v < lo) v = lo;
    else if (v > hi) v = hi;
    offs16 = DivW'(((3 * 32'(scale_q)) >> 1)) << 4;
    num_pos = (pos_q << 4);
    num_neg = DivW'(offs16 * wsum_q);
    div_start = 1'b0;
    div_num = DivW'(scale_q) * DivW'(v - lo);
    div_den = DivW'(hi - lo);
    if (st_q == StNorm && !flat) div_start = 1'b1;
    if (st_q == StCent && wsum_q != '0) begin
      div_start = 1'b1;
      div_num = (num_pos >= num_neg) ? num_pos - num_neg : num_neg - num_pos;
      div_den = wsum_q;
    end
    nvc = flat ? NvW'(smp_q[ch_q]) : NvW'(div_quot);
  end

  always_comb begin
    st_d = st_q;
    ch_d = ch_q;
    unique case (st_q)
      StIdle: if (in_acc) st_d = (command_i == lscc_pkg::CmdCalibrate) ? StOut : StNorm;
      StNorm: st_d = flat ? StWait : StWait;
      StWait: if (flat || div_ctrl.done) begin
        ch_d = ch_q + 1'b1;
        st_d = (ch_q == ChW'(NC - 1)) ? StCent : StNorm;
      end
      StCent: st_d = (wsum_q == '0) ? StOut : StCWait;
      StCWait: if (div_ctrl.done) st_d = StOut;
      StOut: if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  logic [DivW-1:0] w_add;
  assign w_add = DivW'(scale_q) * DivW'(NC - 1 - int'(ch_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ch_q <= '0;
      first_q <= 1'b1;
      ovalid_q <= 1'b0;
      scale_q <= 10'd1000;
      thr_q <= 12'd500;
      for (int i = 0; i < NC; i++) begin
        mn_q[i] <= '0;
        mx_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      ch_q <= ch_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == lscc_pkg::RegNormScale) scale_q <= cfg_data_i[lscc_pkg::ScaleW-1:0];
        if (cfg_idx_i == lscc_pkg::RegDetectThr) thr_q <= cfg_data_i[lscc_pkg::ThrW-1:0];
      end
      if (st_q == StOut && out_free) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      if (st_q == StOut && out_free) begin
        if (cmd_q == lscc_pkg::CmdCalibrate) begin
          first_q <= 1'b0;
          for (int i = 0; i < NC; i++) begin
            if (first_q || smp_q[i] < mn_q[i]) mn_q[i] <= smp_q[i];
            if (first_q || smp_q[i] > mx_q[i]) mx_q[i] <= smp_q[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= command_i;
      smp_q[0] <= sample_0_i;
      smp_q[1] <= sample_1_i;
      smp_q[2] <= sample_2_i;
      smp_q[3] <= sample_3_i;
      pos_q <= '0;
      wsum_q <= '0;
    end
    if (st_q == StWait && (flat || div_ctrl.done)) begin
      nv_q[ch_q] <= nvc;
      if (DivW'(nvc) > DivW'(thr_q)) begin
        pos_q <= pos_q + DivW'(nvc) * w_add;
        wsum_q <= wsum_q + DivW'(nvc);
      end
    end
    if (st_q == StCent) neg_q <= (num_pos < num_neg);
    if (st_q == StOut && out_free) begin
      for (int i = 0; i < NC; i++)
        onorm_q[i] <= (cmd_q == lscc_pkg::CmdCalibrate) ? '0 : nv_q[i][lscc_pkg::NormW-1:0];
      if (cmd_q == lscc_pkg::CmdCalibrate || wsum_q == '0) begin
        err_q <= '0;
        lost_q <= (cmd_q == lscc_pkg::CmdMeasure);
      end else begin
        err_q <= neg_q ? -div_quot[lscc_pkg::ErrW-1:0] : div_quot[lscc_pkg::ErrW-1:0];
        lost_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign line_error_o = err_q;
  assign line_lost_o = lost_q;
  assign norm_0_o = onorm_q[0];
  assign norm_1_o = onorm_q[1];
  assign norm_2_o = onorm_q[2];
  assign norm_3_o = onorm_q[3];
endmodule

/* hw/rtl/lscc_checker.sv */
// Port-level checker for the line sensor block, bound to the top level.
// Depends on lscc_pkg.
module lscc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic signed [lscc_pkg::ErrW-1:0] line_error_o,
  input logic line_lost_o
);
  a_lost_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_lost_o) |-> (line_error_o == '0)) else $error("lost with error");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(line_error_o)))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("accepted while busy");
endmodule

bind line_sensor_calibrate_centroid_top lscc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .line_error_o(line_error_o), .line_lost_o(line_lost_o)
);

/* dv/tb_line_sensor_calibrate_centroid_top.sv */
// Testbench for the line sensor calibrate/centroid block: directed and random words
// against a built-in predictor of the min/max windows and the weighted centroid.
// Depends on lscc_pkg and line_sensor_calibrate_centroid_top.
module tb_line_sensor_calibrate_centroid_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic cmd;
    logic [11:0] smp [4];
  } word_t;

  typedef struct {
    logic [15:0] err;
    logic lost;
    logic [11:0] nrm [4];
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = 1'b0;
  logic [11:0] sample_0_i = '0, sample_1_i = '0, sample_2_i = '0, sample_3_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] line_error_o;
  logic line_lost_o;
  logic [11:0] norm_0_o, norm_1_o, norm_2_o, norm_3_o;
  logic cfg_we_i = 1'b0;
  logic [lscc_pkg::CfgIdxW-1:0] cfg_idx_i = lscc_pkg::RegNormScale;
  logic [lscc_pkg::CfgDataW-1:0] cfg_data_i = '0;

  line_sensor_calibrate_centroid_top dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  word_t pending_words[$];
  result_t expected_results[$];
  int unsigned accepted_words = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit quiet_phase = 1'b0;
  bit timed_out = 1'b0;

  logic [9:0] mdl_scale;
  logic [11:0] mdl_thr;
  logic [11:0] win_lo [4];
  logic [11:0] win_hi [4];
  bit first_cal;

  function automatic result_t predict_position(word_t w);
    result_t r;
    longint unsigned nv, pos, wsum, off;
    longint num, q;
    logic [11:0] v;
    r.err = '0;
    r.lost = 1'b0;
    for (int i = 0; i < 4; i++) r.nrm[i] = '0;
    if (w.cmd == lscc_pkg::CmdCalibrate) begin
      for (int i = 0; i < 4; i++) begin
        if (first_cal) begin
          win_lo[i] = w.smp[i];
          win_hi[i] = w.smp[i];
        end else begin
          if (w.smp[i] < win_lo[i]) win_lo[i] = w.smp[i];
          if (w.smp[i] > win_hi[i]) win_hi[i] = w.smp[i];
        end
      end
      first_cal = 1'b0;
      return r;
    end
    pos = 0;
    wsum = 0;
    for (int i = 0; i < 4; i++) begin
      v = w.smp[i];
      if (win_hi[i] <= win_lo[i]) begin
        nv = 64'(v);
      end else begin
        if (v < win_lo[i]) v = win_lo[i];
        else if (v > win_hi[i]) v = win_hi[i];
        nv = (64'(mdl_scale) * 64'(v - win_lo[i])) / 64'(win_hi[i] - win_lo[i]);
      end
      if (nv > mdl_thr) begin
        pos += nv * 64'(mdl_scale) * 64'(3 - i);
        wsum += nv;
      end
      r.nrm[i] = nv[11:0];
    end
    if (wsum == 0) begin
      r.lost = 1'b1;
    end else begin
      off = (3 * 64'(mdl_scale)) >> 1;
      num = longint'(pos) * 16 - longint'(off) * 16 * longint'(wsum);
      if (num >= 0) q = num / longint'(wsum);
      else q = -((-num) / longint'(wsum));
      r.err = q[15:0];
    end
    return r;
  endfunction

  // Driver: the predictor runs when a word is accepted.
  int unsigned gap_left = 0;
  bit hold_off = 1'b0;
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        w.cmd = command_i;
        w.smp[0] = sample_0_i;
        w.smp[1] = sample_1_i;
        w.smp[2] = sample_2_i;
        w.smp[3] = sample_3_i;
        expected_results.push_back(predict_position(w));
        accepted_words++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!hold_off && pending_words.size() > 0 &&
                     (quiet_phase || $urandom_range(0, 5) != 0)) begin
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          command_i <= w.cmd;
          sample_0_i <= w.smp[0];
          sample_1_i <= w.smp[1];
          sample_2_i <= w.smp[2];
          sample_3_i <= w.smp[3];
        end else begin
          in_valid_i <= 1'b0;
          if (!quiet_phase && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
        end
      end
    end
  end

  // Monitor with random receiver stall bursts.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word err=%0d", line_error_o);
        end else begin
          e = expected_results.pop_front();
          if (line_error_o !== e.err || line_lost_o !== e.lost || norm_0_o !== e.nrm[0] ||
              norm_1_o !== e.nrm[1] || norm_2_o !== e.nrm[2] || norm_3_o !== e.nrm[3]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp err=%0d lost=%0d n=%0d/%0d/%0d/%0d got err=%0d lost=%0d n=%0d/%0d/%0d/%0d",
                       $signed(e.err), e.lost, e.nrm[0], e.nrm[1], e.nrm[2], e.nrm[3],
                       line_error_o, line_lost_o, norm_0_o, norm_1_o, norm_2_o, norm_3_o);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) timed_out = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic add_word(logic cmd, logic [11:0] a, logic [11:0] b, logic [11:0] c,
                          logic [11:0] d);
    word_t w;
    w.cmd = cmd;
    w.smp[0] = a;
    w.smp[1] = b;
    w.smp[2] = c;
    w.smp[3] = d;
    pending_words.push_back(w);
  endtask

  task automatic drain_all();
    while ((pending_words.size() > 0 || in_valid_i || expected_results.size() > 0) &&
           !timed_out)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [lscc_pkg::CfgIdxW-1:0] idx,
                           logic [lscc_pkg::CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lscc_pkg::RegNormScale) mdl_scale = val[9:0];
    else mdl_thr = val;
  endtask

  function automatic logic [11:0] near(logic [11:0] base, int spread);
    int v;
    v = int'(base) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  task automatic random_phase(int n);
    logic [11:0] lo, hi;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 2) begin
        add_word(lscc_pkg::CmdCalibrate, 12'($urandom), 12'($urandom), 12'($urandom),
                 12'($urandom));
      end else if ($urandom_range(0, 9) < 7) begin
        lo = 12'($urandom_range(0, 1500));
        hi = 12'($urandom_range(2500, 4095));
        add_word(lscc_pkg::CmdMeasure, $urandom_range(0, 1) ? near(hi, 600) : near(lo, 600),
                 $urandom_range(0, 1) ? near(hi, 600) : near(lo, 600),
                 $urandom_range(0, 1) ? near(hi, 600) : near(lo, 600),
                 $urandom_range(0, 1) ? near(hi, 600) : near(lo, 600));
      end else begin
        add_word(lscc_pkg::CmdMeasure, 12'($urandom), 12'($urandom), 12'($urandom),
                 12'($urandom));
      end
    end
  endtask

  initial begin
    mdl_scale = 10'd1000;
    mdl_thr = 12'd500;
    first_cal = 1'b1;
    for (int i = 0; i < 4; i++) begin
      win_lo[i] = '0;
      win_hi[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Flat windows from reset pass raw samples; then first calibrate loads all channels.
    add_word(lscc_pkg::CmdMeasure, 12'd0, 12'd4095, 12'd600, 12'd300);
    add_word(lscc_pkg::CmdMeasure, 12'd0, 12'd0, 12'd0, 12'd0);
    add_word(lscc_pkg::CmdCalibrate, 12'd2000, 12'd2100, 12'd2200, 12'd2300);
    add_word(lscc_pkg::CmdMeasure, 12'd2000, 12'd4095, 12'd0, 12'd2300);
    add_word(lscc_pkg::CmdCalibrate, 12'd0, 12'd100, 12'd200, 12'd300);
    add_word(lscc_pkg::CmdCalibrate, 12'd4095, 12'd4000, 12'd3900, 12'd3800);
    add_word(lscc_pkg::CmdMeasure, 12'd4095, 12'd0, 12'd0, 12'd0);
    add_word(lscc_pkg::CmdMeasure, 12'd0, 12'd0, 12'd0, 12'd4095);
    add_word(lscc_pkg::CmdMeasure, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    add_word(lscc_pkg::CmdMeasure, 12'd0, 12'd0, 12'd0, 12'd0);
    add_word(lscc_pkg::CmdMeasure, 12'd2000, 12'd3000, 12'd1000, 12'd0);
    add_word(lscc_pkg::CmdMeasure, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
    random_phase(10);
    drain_all();
    // Pause until every result has come is done by drain_all above.

    write_reg(lscc_pkg::RegNormScale, 12'd1023);
    write_reg(lscc_pkg::RegDetectThr, 12'd0);
    random_phase(300);
    drain_all();
    write_reg(lscc_pkg::RegNormScale, 12'd1);
    write_reg(lscc_pkg::RegDetectThr, 12'd4095);
    random_phase(150);
    drain_all();
    write_reg(lscc_pkg::RegNormScale, 12'd0);
    write_reg(lscc_pkg::RegDetectThr, 12'd0);
    add_word(lscc_pkg::CmdMeasure, 12'd4095, 12'd4095, 12'd0, 12'd4095);
    random_phase(50);
    drain_all();
    write_reg(lscc_pkg::RegNormScale, 12'hFFF);
    write_reg(lscc_pkg::RegDetectThr, 12'd200);
    random_phase(400);
    drain_all();
    for (int p = 0; p < 3; p++) begin
      write_reg(lscc_pkg::RegNormScale, 12'($urandom_range(1, 1023)));
      write_reg(lscc_pkg::RegDetectThr, 12'($urandom_range(0, 1100)));
      random_phase(200);
      drain_all();
    end
    quiet_phase = 1'b1;
    random_phase(120);
    drain_all();

    if (!timed_out && mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_line_sensor_calibrate_centroid_top: done, clean");
    end else begin
      $display("tb_line_sensor_calibrate_centroid_top: done, errors");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("tb_line_sensor_calibrate_centroid_top: done, errors");
    $finish;
  end
endmodule
